// ===== hdl/drop_oldest_ring_with_gap_count_top_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the drop-oldest receive ring
// Clocked assertion helpers shared by the RTL files of the block.
// ---------------------------------------------------------------------------
`ifndef DROP_OLDEST_RING_WITH_GAP_COUNT_TOP_MACROS_SVH
`define DROP_OLDEST_RING_WITH_GAP_COUNT_TOP_MACROS_SVH

`ifndef SYNTH
// property checked at every rising clock edge outside reset
`define DORG_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("dorg assertion failed");
// condition that must never be true outside reset
`define DORG_ASSERT_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("dorg forbidden condition seen");
`else
`define DORG_ASSERT(lbl, clk, rst_n, prop)
`define DORG_ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif

`endif

// ===== hdl/dorg_pkg.sv =====
// ---------------------------------------------------------------------------
// dorg_pkg
// Shared widths, defaults, op codes and the per-request result record.
// ---------------------------------------------------------------------------
package dorg_pkg;

	localparam int WORD_W        = 64;
	localparam int FILL_W        = 7;
	localparam int DEPTH_DEF     = 64;
	localparam int ITEM_BITS_DEF = 64;

	localparam logic [FILL_W-1:0] DEPTH_RST = 7'd64;

	localparam logic OP_PUSH = 1'b0;
	localparam logic OP_POP  = 1'b1;

	typedef struct packed {
		logic              pop_valid;
		logic              dropped;
		logic [FILL_W-1:0] fill;
		logic [WORD_W-1:0] overflow;
		logic [WORD_W-1:0] gap;
	} res_t;

endpackage

// ===== hdl/dorg_ram.sv =====
// ---------------------------------------------------------------------------
// dorg_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ---------------------------------------------------------------------------
module dorg_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ===== hdl/dorg_ctrl.sv =====
// ---------------------------------------------------------------------------
// dorg_ctrl
// Ring pointers, fill count, sequence tracking and the two running counters.
// ---------------------------------------------------------------------------
`include "drop_oldest_ring_with_gap_count_top_macros.svh"

module dorg_ctrl import dorg_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_wr_en,
	input  logic [FILL_W-1:0]        cfg_wr_data,
	input  logic                     accept,
	input  logic                     op,
	input  logic [WORD_W-1:0]        seq,
	output logic                     ram_wr_en,
	output logic [$clog2(DEPTH)-1:0] ram_wr_addr,
	output logic                     ram_rd_en,
	output logic [$clog2(DEPTH)-1:0] ram_rd_addr,
	output res_t                     res
);

	localparam int IDX_W     = $clog2(DEPTH);
	localparam int CMP_W     = (IDX_W + 1 > FILL_W) ? IDX_W + 1 : FILL_W;
	localparam int DEPTH_CAP = (DEPTH < 127) ? DEPTH : 127;

	logic [FILL_W-1:0] depth_cfg_q;
	logic [IDX_W-1:0]  head_q, tail_q;
	logic [FILL_W-1:0] count_q;
	logic [WORD_W-1:0] expected_q;
	logic              seen_q;
	logic [WORD_W-1:0] overflow_q, gap_q;

	logic [FILL_W-1:0] live_d;
	logic              full, nonempty;
	logic [IDX_W-1:0]  head_nxt, tail_nxt;
	logic [FILL_W-1:0] count_nxt;
	logic [WORD_W-1:0] overflow_nxt, gap_nxt, expected_nxt;

	// next slot; wraps at the live depth or at the physical end
	function automatic logic [IDX_W-1:0] adv(input logic [IDX_W-1:0] idx,
	                                        input logic [FILL_W-1:0] d);
		logic [CMP_W-1:0] n;
		n = CMP_W'(idx) + CMP_W'(1);
		if (n >= CMP_W'(d) || n >= CMP_W'(DEPTH)) begin
			adv = '0;
		end else begin
			adv = n[IDX_W-1:0];
		end
	endfunction

	always_comb begin
		if (depth_cfg_q == '0) begin
			live_d = FILL_W'(1);
		end else if (depth_cfg_q > FILL_W'(DEPTH_CAP)) begin
			live_d = FILL_W'(DEPTH_CAP);
		end else begin
			live_d = depth_cfg_q;
		end
	end

	assign full     = (count_q >= live_d);
	assign nonempty = (count_q != '0);

	always_comb begin
		head_nxt     = head_q;
		tail_nxt     = tail_q;
		count_nxt    = count_q;
		overflow_nxt = overflow_q;
		gap_nxt      = gap_q;
		expected_nxt = expected_q;
		res.pop_valid = 1'b0;
		res.dropped   = 1'b0;
		if (op == OP_PUSH) begin
			// equal seq adds zero, so no compare is needed
			if (seen_q) begin
				gap_nxt = gap_q + seq - expected_q;
			end
			expected_nxt = seq + WORD_W'(1);
			if (full) begin
				head_nxt     = adv(head_q, live_d);
				overflow_nxt = overflow_q + WORD_W'(1);
				res.dropped  = 1'b1;
			end else begin
				count_nxt = count_q + FILL_W'(1);
			end
			tail_nxt = adv(tail_q, live_d);
		end else if (nonempty) begin
			res.pop_valid = 1'b1;
			head_nxt      = adv(head_q, live_d);
			count_nxt     = count_q - FILL_W'(1);
		end
		res.fill     = count_nxt;
		res.overflow = overflow_nxt;
		res.gap      = gap_nxt;
	end

	assign ram_wr_en   = accept && (op == OP_PUSH);
	assign ram_wr_addr = tail_q;
	assign ram_rd_en   = accept && (op == OP_POP) && nonempty;
	assign ram_rd_addr = head_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_cfg_q <= DEPTH_RST;
			head_q      <= '0;
			tail_q      <= '0;
			count_q     <= '0;
			expected_q  <= '0;
			seen_q      <= 1'b0;
			overflow_q  <= '0;
			gap_q       <= '0;
		end else begin
			if (cfg_wr_en) begin
				depth_cfg_q <= cfg_wr_data;
			end
			if (accept) begin
				head_q     <= head_nxt;
				tail_q     <= tail_nxt;
				count_q    <= count_nxt;
				expected_q <= expected_nxt;
				overflow_q <= overflow_nxt;
				gap_q      <= gap_nxt;
				if (op == OP_PUSH) begin
					seen_q <= 1'b1;
				end
			end
		end
	end

	`DORG_ASSERT(a_idx_range, clk, arst_n, (head_q < IDX_W'(DEPTH - 1) || head_q == IDX_W'(DEPTH - 1)) && (tail_q < IDX_W'(DEPTH - 1) || tail_q == IDX_W'(DEPTH - 1)))
	`DORG_ASSERT(a_drop_counts, clk, arst_n, (accept && res.dropped) |=> overflow_q == $past(overflow_q) + WORD_W'(1))
	`DORG_ASSERT_NEVER(a_drop_empty, clk, arst_n, accept && res.dropped && !nonempty)

endmodule

// ===== hdl/drop_oldest_ring_with_gap_count_top.sv =====
// ---------------------------------------------------------------------------
// drop_oldest_ring_with_gap_count_top
// Receive ring for sequenced items that overwrites its oldest entry when full.
//
// Requests arrive on in_valid/in_stall with op (push or pop), seq and
// item_data; each accepted request gives exactly one result on
// out_valid/out_stall. A push stores the data word, tracks sequence gaps
// and may drop the oldest entry; a pop returns the oldest word or reports
// an empty ring. fill_count, overflow_total and gap_total show the state
// after the request.
// Timing: an accepted request's result record is registered in s1 and
// moves to the output register, with the RAM read data, when the output
// is free; out_valid then rises. Throughput: one request per cycle while
// in_stall is low; the ring lives in a RAM with a registered read
// port, and the state update is a single pass between the request edge
// and the result stage.
// Stall: a stalled result is held in the output register, one more
// request is parked in the stage behind it, and in_stall rises only
// when both are occupied. cfg_wr_en/cfg_wr_data set the depth in use
// (0 acts as 1, above the ring size acts as the ring size); write it
// only while idle. Reset empties the ring, clears the counters and sets
// the depth setting to 64 (capped at the ring size); RAM contents are not cleared.
// ---------------------------------------------------------------------------
`include "drop_oldest_ring_with_gap_count_top_macros.svh"

module drop_oldest_ring_with_gap_count_top import dorg_pkg::*; #(
	parameter int DEPTH     = DEPTH_DEF,
	parameter int ITEM_BITS = ITEM_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wr_en,
	input  logic [FILL_W-1:0] cfg_wr_data,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic              op,
	input  logic [WORD_W-1:0] seq,
	input  logic [WORD_W-1:0] item_data,
	output logic              out_valid,
	input  logic              out_stall,
	output logic              pop_valid,
	output logic [WORD_W-1:0] pop_data,
	output logic              dropped_oldest,
	output logic [FILL_W-1:0] fill_count,
	output logic [WORD_W-1:0] overflow_total,
	output logic [WORD_W-1:0] gap_total
);

	localparam int IDX_W = $clog2(DEPTH);

	logic                 accept;
	logic                 out_free, s1_move;
	logic                 ram_wr_en, ram_rd_en;
	logic [IDX_W-1:0]     ram_wr_addr, ram_rd_addr;
	logic [ITEM_BITS-1:0] ram_rd_data;
	res_t                 res;

	logic                 s1_valid_q;
	res_t                 res_s1;

	logic                 out_valid_q;
	res_t                 out_res_q;
	logic [WORD_W-1:0]    out_data_q;

	assign out_free = !out_valid_q || !out_stall;
	assign s1_move  = s1_valid_q && out_free;
	assign in_stall = s1_valid_q && !out_free;
	assign accept   = in_valid && !in_stall;

	dorg_ctrl #(
		.DEPTH (DEPTH)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.accept      (accept),
		.op          (op),
		.seq         (seq),
		.ram_wr_en   (ram_wr_en),
		.ram_wr_addr (ram_wr_addr),
		.ram_rd_en   (ram_rd_en),
		.ram_rd_addr (ram_rd_addr),
		.res         (res)
	);

	dorg_ram #(
		.WIDTH (ITEM_BITS),
		.DEPTH (DEPTH)
	) u_ram (
		.clk     (clk),
		.wr_en   (ram_wr_en),
		.wr_addr (ram_wr_addr),
		.wr_data (item_data[ITEM_BITS-1:0]),
		.rd_en   (ram_rd_en),
		.rd_addr (ram_rd_addr),
		.rd_data (ram_rd_data)
	);

	// s1 pairs the request's result record with the RAM read data,
	// which holds until the next pop of a nonempty ring is accepted
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			s1_valid_q <= accept || (s1_valid_q && !out_free);
			if (out_free) begin
				out_valid_q <= s1_valid_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_s1 <= res;
		end
		if (s1_move) begin
			out_res_q  <= res_s1;
			out_data_q <= res_s1.pop_valid ? WORD_W'(ram_rd_data) : '0;
		end
	end

	assign out_valid      = out_valid_q;
	assign pop_valid      = out_res_q.pop_valid;
	assign pop_data       = out_data_q;
	assign dropped_oldest = out_res_q.dropped;
	assign fill_count     = out_res_q.fill;
	assign overflow_total = out_res_q.overflow;
	assign gap_total      = out_res_q.gap;

	`DORG_ASSERT(a_s1_drains, clk, arst_n, (s1_valid_q && !out_valid_q) |=> out_valid_q)
	`DORG_ASSERT(a_empty_pop_zero, clk, arst_n, (out_valid_q && !out_res_q.pop_valid) |-> out_data_q == '0)
	`DORG_ASSERT_NEVER(a_pop_and_drop, clk, arst_n, out_valid_q && out_res_q.pop_valid && out_res_q.dropped)

endmodule
